[sv/pts_pkg.sv]
// Shared constants, codes and types for the prime test and search block.
package pts_pkg;

  // Width that values are kept to, never wider than the 32-bit data field.
  localparam int WIDTH = 32;
  localparam int LW    = (WIDTH < 32) ? WIDTH : 32;
  // Divisors stay below about the square root of the largest candidate.
  localparam int DW    = LW / 2 + 2;
  // Width of the running divisor square.
  localparam int SQW   = LW + 2;
  // Bit counter of the serial remainder unit.
  localparam int CW    = $clog2(LW + 1);

  localparam logic [LW-1:0] LIM_MAX = '1;

  localparam logic [1:0] OP_TEST = 2'd0;
  localparam logic [1:0] OP_NEXT = 2'd1;
  localparam logic [1:0] OP_PREV = 2'd2;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_RANGE    = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  typedef struct packed {
    logic done;
    logic prime;
  } trial_status_t;

endpackage

[sv/pts_rem_serial.sv]
// Bit-serial remainder unit: one dividend bit per cycle, restoring form.
module pts_rem_serial (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [pts_pkg::LW-1:0] dividend,
  input  logic [pts_pkg::DW-1:0] divisor,
  output logic                  done,
  output logic                  zero
);

  logic [pts_pkg::LW-1:0] sh;
  logic [pts_pkg::DW-1:0] rem;
  logic [pts_pkg::CW-1:0] cnt;
  logic                   busy;
  logic [pts_pkg::DW:0]   trial;
  logic [pts_pkg::DW:0]   diff;

  assign trial = {rem, sh[pts_pkg::LW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign zero  = (rem == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == pts_pkg::CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= pts_pkg::CW'(pts_pkg::LW);
      end else if (busy) begin
        cnt <= cnt - pts_pkg::CW'(1);
        if (cnt == pts_pkg::CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // A borrow means the partial remainder was below the divisor and is kept.
  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= dividend;
      rem <= '0;
    end else if (busy) begin
      sh  <= sh << 1;
      rem <= diff[pts_pkg::DW] ? trial[pts_pkg::DW-1:0] : diff[pts_pkg::DW-1:0];
    end
  end

endmodule

[sv/pts_trial.sv]
// Trial division of one candidate by 3, 5, 7, ... while the divisor square fits.
module pts_trial (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [pts_pkg::LW-1:0] cand,
  output pts_pkg::trial_status_t status
);

  typedef enum logic [2:0] {
    T_IDLE  = 3'b001,
    T_CHECK = 3'b010,
    T_WAIT  = 3'b100
  } tstate_t;

  tstate_t                 state;
  logic [pts_pkg::LW-1:0]  n;
  logic [pts_pkg::DW-1:0]  d;
  logic [pts_pkg::SQW-1:0] sq;
  logic                    sq_over;
  logic                    rem_start;
  logic                    rem_done;
  logic                    rem_zero;

  assign sq_over   = (sq > pts_pkg::SQW'(n));
  assign rem_start = (state == T_CHECK) && !sq_over;

  pts_rem_serial u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (n),
    .divisor  (d),
    .done     (rem_done),
    .zero     (rem_zero)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= T_IDLE;
      status <= '0;
    end else begin
      case (state)
        T_IDLE: begin
          // Values below four and even values are settled without division.
          if (start && (cand < pts_pkg::LW'(4) || !cand[0])) begin
            status.done  <= 1'b1;
            status.prime <= (cand >= pts_pkg::LW'(2)) && (cand < pts_pkg::LW'(4));
          end else begin
            status.done <= 1'b0;
            if (start) begin
              state <= T_CHECK;
            end
          end
        end
        T_CHECK: begin
          if (sq_over) begin
            status.done  <= 1'b1;
            status.prime <= 1'b1;
            state        <= T_IDLE;
          end else begin
            status.done <= 1'b0;
            state       <= T_WAIT;
          end
        end
        T_WAIT: begin
          if (rem_done && rem_zero) begin
            status.done  <= 1'b1;
            status.prime <= 1'b0;
            state        <= T_IDLE;
          end else begin
            status.done <= 1'b0;
            if (rem_done) begin
              state <= T_CHECK;
            end
          end
        end
        default: begin
          status.done <= 1'b0;
          state       <= T_IDLE;
        end
      endcase
    end
  end

  // (d + 2)^2 = d^2 + 4d + 4, so the square follows the divisor without a multiplier.
  always_ff @(posedge clk) begin
    if (state == T_IDLE && start) begin
      n  <= cand;
      d  <= pts_pkg::DW'(3);
      sq <= pts_pkg::SQW'(9);
    end else if (state == T_WAIT && rem_done && !rem_zero) begin
      d  <= d + pts_pkg::DW'(2);
      sq <= sq + (pts_pkg::SQW'(d) << 2) + pts_pkg::SQW'(4);
    end
  end

endmodule

[sv/prime_test_and_search.sv]
// Top level of the prime test and search block: operation sequencer and result register.
//
// Input channel s_*: s_tuser carries the operation (0 test, 1 next prime at or
// above, 2 previous prime at or below, 3 acts as test); s_tdata carries the value.
// Output channel m_*: m_tdata carries the prime found (the value itself for a
// test); m_tuser carries the prime flag and the error code.
// One item is worked on at a time. Each candidate is checked by trial division
// with a bit-serial remainder unit, one odd divisor after another while the
// divisor square does not exceed the candidate; even or small values are
// settled without division. A search repeats this for every odd candidate tried.
// That remainder unit sets the throughput. Results go through an output
// register: a new item is accepted while a finished result still waits, and
// the sequencer holds its result when the receiver stalls until the register
// frees. Reset empties the output register and returns all control to idle.
module prime_test_and_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [1:0]  s_tuser,   // [1:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] prime_value
  output logic [2:0]  m_tuser    // [0] prime_flag, [2:1] error_code
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PREP   = 5'b00010,
    S_START  = 5'b00100,
    S_WAIT   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t                 state;
  logic [1:0]             op;
  logic [pts_pkg::LW-1:0] v;
  logic [pts_pkg::LW-1:0] q;
  logic [pts_pkg::LW-1:0] res;
  logic                   flag;
  logic [1:0]             err;
  logic                   in_acc;
  logic                   trial_start;
  pts_pkg::trial_status_t tr;

  assign s_tready    = (state == S_IDLE);
  assign in_acc      = s_tvalid && s_tready;
  assign trial_start = (state == S_START);

  pts_trial u_trial (
    .clk    (clk),
    .rst    (rst),
    .start  (trial_start),
    .cand   (q),
    .status (tr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_FINISH) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          if (op == pts_pkg::OP_NEXT) begin
            state <= (v <= pts_pkg::LW'(2)) ? S_FINISH : S_START;
          end else if (op == pts_pkg::OP_PREV) begin
            state <= (v <= pts_pkg::LW'(3)) ? S_FINISH : S_START;
          end else begin
            state <= S_START;
          end
        end
        S_START: state <= S_WAIT;
        S_WAIT: begin
          if (tr.done) begin
            if (op == pts_pkg::OP_NEXT && !tr.prime &&
                q < pts_pkg::LIM_MAX - pts_pkg::LW'(1)) begin
              state <= S_START;
            end else if (op == pts_pkg::OP_PREV && !tr.prime) begin
              state <= S_START;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op <= s_tuser;
      v  <= s_tdata[pts_pkg::LW-1:0];
    end
    case (state)
      S_PREP: begin
        flag <= 1'b0;
        if (op == pts_pkg::OP_NEXT) begin
          err <= pts_pkg::ERR_OK;
          res <= (v <= pts_pkg::LW'(2)) ? pts_pkg::LW'(2) : '0;
          q   <= v | pts_pkg::LW'(1);
        end else if (op == pts_pkg::OP_PREV) begin
          err <= (v < pts_pkg::LW'(2)) ? pts_pkg::ERR_RANGE : pts_pkg::ERR_OK;
          res <= (v >= pts_pkg::LW'(2) && v <= pts_pkg::LW'(3)) ? v : '0;
          q   <= v[0] ? v : v - pts_pkg::LW'(1);
        end else begin
          err <= pts_pkg::ERR_OK;
          res <= '0;
          q   <= v;
        end
      end
      S_WAIT: begin
        if (tr.done) begin
          if (op == pts_pkg::OP_NEXT) begin
            if (tr.prime) begin
              res <= q;
            end else if (q >= pts_pkg::LIM_MAX - pts_pkg::LW'(1)) begin
              err <= pts_pkg::ERR_OVERFLOW;
            end else begin
              q <= q + pts_pkg::LW'(2);
            end
          end else if (op == pts_pkg::OP_PREV) begin
            if (tr.prime) begin
              res <= q;
            end else begin
              q <= q - pts_pkg::LW'(2);
            end
          end else begin
            res  <= q;
            flag <= tr.prime;
          end
        end
      end
      default: ;
    endcase
    if (state == S_FINISH && (!m_tvalid || m_tready)) begin
      m_tdata <= 32'(res);
      m_tuser <= {err, flag};
    end
  end

  // The trial unit only reports while the sequencer waits for it.
  a_trial_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    tr.done |-> state == S_WAIT)
    else $error("trial result outside of wait state");

  // Search candidates are always odd.
  a_search_odd: assert property (@(posedge clk) disable iff (rst)
    (state == S_START && (op == pts_pkg::OP_NEXT || op == pts_pkg::OP_PREV)) |-> q[0])
    else $error("even search candidate");

  // An error result carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2:1] != pts_pkg::ERR_OK) |-> m_tdata == 32'd0)
    else $error("error result with nonzero value");

  // A prime flag never comes with an error.
  a_flag_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tuser[2:1] == pts_pkg::ERR_OK)
    else $error("prime flag with error code");

endmodule
